### design/mrbs_pkg.sv
// Shared widths, result codes and colour codes for the max-radius bipartite split block.
// No dependencies; every other file imports this package.
package mrbs_pkg;

  localparam int COORD_W   = 16;  // Q8.8 coordinate
  localparam int ABS_W     = 16;  // magnitude of a coordinate difference
  localparam int SQ_W      = 32;  // one squared difference
  localparam int DSQ_W     = 33;  // sum of two squares
  localparam int ROOT_W    = 17;  // integer square root of a squared distance
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int SQ_CNT_W  = 5;
  localparam int VAL_W     = 16;
  localparam int IDX_OUT_W = 6;
  localparam int COL_W     = 2;

  localparam logic [SQ_CNT_W-1:0] SQ_LAST_STEP = SQ_CNT_W'(ROOT_W - 1);

  localparam logic KIND_DIST   = 1'b0;
  localparam logic KIND_COLOUR = 1'b1;

  localparam logic [COL_W-1:0] COL_NONE = 2'd0;
  localparam logic [COL_W-1:0] COL_A    = 2'd1;
  localparam logic [COL_W-1:0] COL_B    = 2'd2;

endpackage

### design/mrbs_front.sv
// Input side: accepts points, writes them to the point store and posts one job per set.
// Depends on mrbs_pkg.
module mrbs_front import mrbs_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int IW = $clog2(MAX_POINTS),
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic                      last_point,
  output logic                      wr_en,
  output logic [IW-1:0]             wr_addr,
  output logic [COORD_W-1:0]        wr_x,
  output logic [COORD_W-1:0]        wr_y,
  output logic                      job_push,
  output logic [CW-1:0]             job_n,
  input  logic                      run_done
);

  logic          busy;
  logic [CW-1:0] count;
  logic          accept;
  logic          room;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign room     = (count < CW'(MAX_POINTS));

  assign wr_en    = accept && room;
  assign wr_addr  = count[IW-1:0];
  assign wr_x     = coord_x;
  assign wr_y     = coord_y;
  assign job_push = accept && last_point;
  assign job_n    = room ? count + CW'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else begin
      if (job_push) begin
        // hold input until the whole run has been loaded for output
        busy  <= 1'b1;
        count <= '0;
      end else begin
        if (wr_en) begin
          count <= count + CW'(1);
        end
        if (run_done) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### design/mrbs_queue.sv
// Two-entry job queue between the input side and the search engine.
// Depends on mrbs_pkg.
module mrbs_queue import mrbs_pkg::*; #(
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [CW-1:0] push_n,
  input  logic          pop,
  output logic          job_valid,
  output logic [CW-1:0] job_n
);

  logic [CW-1:0] slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign job_valid = (fill != 2'd0);
  assign job_n     = slot[rd_ptr];
  assign do_push   = push && (fill != 2'd2);
  assign do_pop    = pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### design/mrbs_dist.sv
// Point store and four-stage squared-distance unit: read, difference, square, sum.
// Depends on mrbs_pkg.
module mrbs_dist import mrbs_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int IW = $clog2(MAX_POINTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IW-1:0]      wr_addr,
  input  logic [COORD_W-1:0] wr_x,
  input  logic [COORD_W-1:0] wr_y,
  input  logic               req,
  input  logic [IW-1:0]      addr_a,
  input  logic [IW-1:0]      addr_b,
  output logic               done,
  output logic [DSQ_W-1:0]   dsq
);

  logic [COORD_W-1:0] x_mem [MAX_POINTS];
  logic [COORD_W-1:0] y_mem [MAX_POINTS];
  logic [COORD_W-1:0] xa, xb, ya, yb;
  logic [ABS_W-1:0]   ax, ay;
  logic [SQ_W-1:0]    sx, sy;
  logic               s1, s2, s3;
  logic signed [COORD_W:0] dx, dy;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
    xa <= x_mem[addr_a];
    xb <= x_mem[addr_b];
    ya <= y_mem[addr_a];
    yb <= y_mem[addr_b];
  end

  always_comb begin
    dx = $signed({xa[COORD_W-1], xa}) - $signed({xb[COORD_W-1], xb});
    dy = $signed({ya[COORD_W-1], ya}) - $signed({yb[COORD_W-1], yb});
  end

  always_ff @(posedge clk) begin
    ax  <= dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
    ay  <= dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    sx  <= ax * ax;
    sy  <= ay * ay;
    dsq <= DSQ_W'(sx) + DSQ_W'(sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      s2   <= 1'b0;
      s3   <= 1'b0;
      done <= 1'b0;
    end else begin
      s1   <= req;
      s2   <= s1;
      s3   <= s2;
      done <= s3;
    end
  end

endmodule

### design/mrbs_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on mrbs_pkg.
module mrbs_isqrt import mrbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DSQ_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]    rad;
  logic [REM_W-1:0]    rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic                busy;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == SQ_LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + SQ_CNT_W'(1);
        if (cnt == SQ_LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### design/mrbs_back.sv
// Search engine: pair sweep, graph two-colouring, square root and result output.
// Depends on mrbs_pkg, mrbs_dist and mrbs_isqrt.
module mrbs_back import mrbs_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int IW = $clog2(MAX_POINTS),
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  logic [CW-1:0]        job_n,
  output logic                 job_pop,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  logic [COORD_W-1:0]   wr_x,
  input  logic [COORD_W-1:0]   wr_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 kind,
  output logic [IDX_OUT_W-1:0] point_index,
  output logic [VAL_W-1:0]     value,
  output logic                 last_result,
  output logic                 run_done
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PAIR  = 10'b0000000010,
    S_PWAIT = 10'b0000000100,
    S_CINIT = 10'b0000001000,
    S_CROOT = 10'b0000010000,
    S_CPICK = 10'b0000100000,
    S_CSCAN = 10'b0001000000,
    S_CWAIT = 10'b0010000000,
    S_SQRT  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t              state;
  logic [CW-1:0]       n, i, j, k, e;
  logic [IW-1:0]       v;
  logic [DSQ_W-1:0]    dtest, best, fail;
  logic                fail_valid;
  logic [MAX_POINTS-1:0] vis, c2, proc, res_vis, res_c2, nmask;
  logic [MAX_POINTS-1:0] root_cand, pick_cand;
  logic [VAL_W-1:0]    half;

  logic                d_req, d_done;
  logic [IW-1:0]       d_a, d_b;
  logic [DSQ_W-1:0]    d_sq;
  logic                sq_start, sq_done;
  logic [ROOT_W-1:0]   sq_root;

  logic                pairs_over;
  logic [IW-1:0]       kx;
  logic [CW-1:0]       em;
  logic [IW-1:0]       ex;
  logic                out_free;

  function automatic logic [IW-1:0] lowest(input logic [MAX_POINTS-1:0] m);
    logic [IW-1:0] r;
    r = '0;
    for (int p = MAX_POINTS - 1; p >= 0; p--) begin
      if (m[p]) r = IW'(p);
    end
    return r;
  endfunction

  always_comb begin
    for (int p = 0; p < MAX_POINTS; p++) begin
      nmask[p] = (CW'(p) < n);
    end
  end

  assign root_cand  = ~vis & nmask;
  assign pick_cand  = vis & ~proc;
  assign pairs_over = ((CW + 1)'(i) + (CW + 1)'(1)) >= (CW + 1)'(n);
  assign kx         = k[IW-1:0];
  assign em         = e - CW'(1);
  assign ex         = em[IW-1:0];
  assign out_free   = !out_valid || !out_stall;
  assign job_pop    = (state == S_IDLE) && job_valid;

  always_comb begin
    d_req = 1'b0;
    d_a   = i[IW-1:0];
    d_b   = j[IW-1:0];
    case (state)
      S_PAIR: begin
        d_req = !pairs_over && (j < n);
      end
      S_CSCAN: begin
        d_a   = v;
        d_b   = kx;
        d_req = (k < n);
      end
      default: begin
        d_req = 1'b0;
      end
    endcase
  end

  assign sq_start = (state == S_PAIR) && pairs_over;

  mrbs_dist #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_dist (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_x(wr_x), .wr_y(wr_y),
    .req(d_req), .addr_a(d_a), .addr_b(d_b),
    .done(d_done), .dsq(d_sq)
  );

  mrbs_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(best),
    .done(sq_done), .root(sq_root)
  );

  // output register: load a transaction when free, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      run_done  <= 1'b0;
    end else begin
      run_done <= (state == S_EMIT) && out_free && (e == n);
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fail_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            n          <= job_n;
            i          <= '0;
            j          <= CW'(1);
            best       <= '0;
            fail_valid <= 1'b0;
            res_vis    <= '0;
            res_c2     <= '0;
            state      <= S_PAIR;
          end
        end
        S_PAIR: begin
          if (pairs_over) begin
            state <= S_SQRT;
          end else if (j >= n) begin
            i <= i + CW'(1);
            j <= i + CW'(2);
          end else begin
            state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (d_done) begin
            dtest <= d_sq;
            j     <= j + CW'(1);
            // skip distances already settled either way; bipartiteness is monotone
            if (d_sq > best && (!fail_valid || d_sq < fail)) begin
              state <= S_CINIT;
            end else begin
              state <= S_PAIR;
            end
          end
        end
        S_CINIT: begin
          vis   <= '0;
          c2    <= '0;
          proc  <= '0;
          state <= S_CROOT;
        end
        S_CROOT: begin
          if (root_cand == '0) begin
            best    <= dtest;
            res_vis <= vis;
            res_c2  <= c2;
            state   <= S_PAIR;
          end else begin
            // lowest uncoloured point opens a new component with colour A
            vis[lowest(root_cand)] <= 1'b1;
            c2[lowest(root_cand)]  <= 1'b0;
            state                  <= S_CPICK;
          end
        end
        S_CPICK: begin
          if (pick_cand == '0) begin
            state <= S_CROOT;
          end else begin
            v                       <= lowest(pick_cand);
            proc[lowest(pick_cand)] <= 1'b1;
            k                       <= '0;
            state                   <= S_CSCAN;
          end
        end
        S_CSCAN: begin
          if (k >= n) begin
            state <= S_CPICK;
          end else begin
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (d_done) begin
            k <= k + CW'(1);
            if (kx != v && d_sq < dtest && vis[kx] && c2[kx] == c2[v]) begin
              fail       <= dtest;
              fail_valid <= 1'b1;
              state      <= S_PAIR;
            end else begin
              state <= S_CSCAN;
              if (kx != v && d_sq < dtest && !vis[kx]) begin
                vis[kx] <= 1'b1;
                c2[kx]  <= ~c2[v];
              end
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            half  <= VAL_W'(sq_root >> 1);
            e     <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            e <= e + CW'(1);
            if (e == '0) begin
              kind        <= KIND_DIST;
              point_index <= '0;
              value       <= half;
              last_result <= (n == '0);
            end else begin
              kind        <= KIND_COLOUR;
              point_index <= IDX_OUT_W'(em);
              value       <= VAL_W'(res_vis[ex] ? (res_c2[ex] ? COL_B : COL_A) : COL_NONE);
              last_result <= (e == n);
            end
            if (e == n) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/max_radius_bipartite_split.sv
// Top level of the max-radius bipartite split block: input side, job queue, search engine.
// Depends on mrbs_pkg, mrbs_front, mrbs_queue and mrbs_back.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | coord_x, coord_y, last_point
//  output  | out_valid / out_stall| kind, point_index, value, last_result
//
// Points load one per cycle while in_stall is low. The point marking the end of a set starts a
// search over all point pairs, with a two-colouring trial for each distance not yet settled;
// the distance unit is shared by both. The square root follows, then N+1 results for N points,
// one per cycle unless stalled.
// Input stalls from the end of a set until the last result has been loaded for output.
// Synchronous reset clears control only; the point store holds no reset value.
module max_radius_bipartite_split import mrbs_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic                      last_point,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      kind,
  output logic [IDX_OUT_W-1:0]      point_index,
  output logic [VAL_W-1:0]          value,
  output logic                      last_result
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [COORD_W-1:0] wr_x, wr_y;
  logic               job_push, job_pop, job_valid, run_done;
  logic [CW-1:0]      push_n, job_n;

  mrbs_front #(.MAX_POINTS(MAX_POINTS), .IW(IW), .CW(CW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .coord_x(coord_x), .coord_y(coord_y), .last_point(last_point),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_x(wr_x), .wr_y(wr_y),
    .job_push(job_push), .job_n(push_n), .run_done(run_done)
  );

  mrbs_queue #(.CW(CW)) u_queue (
    .clk(clk), .rst(rst),
    .push(job_push), .push_n(push_n),
    .pop(job_pop), .job_valid(job_valid), .job_n(job_n)
  );

  mrbs_back #(.MAX_POINTS(MAX_POINTS), .IW(IW), .CW(CW)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_n(job_n), .job_pop(job_pop),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_x(wr_x), .wr_y(wr_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .point_index(point_index), .value(value),
    .last_result(last_result), .run_done(run_done)
  );

endmodule

### design/mrbs_checker.sv
// Port-level checks for the max-radius bipartite split block, bound to the top level.
// Depends on mrbs_pkg and max_radius_bipartite_split.
module mrbs_checker import mrbs_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 kind,
  input logic [IDX_OUT_W-1:0] point_index,
  input logic [VAL_W-1:0]     value,
  input logic                 last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(kind))
    else $error("stalled result changed or dropped");

  a_dist_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DIST |-> point_index == '0)
    else $error("distance result carries a point index");

  a_colour_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_COLOUR |->
      value == VAL_W'(COL_NONE) || value == VAL_W'(COL_A) || value == VAL_W'(COL_B))
    else $error("colour out of range");

  a_first_colour: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && kind == KIND_DIST && !last_result |=>
      !out_valid || (kind == KIND_COLOUR && point_index == '0))
    else $error("colour of point zero must follow the distance");

endmodule

bind max_radius_bipartite_split mrbs_checker u_mrbs_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .kind(kind), .point_index(point_index), .value(value), .last_result(last_result)
);
